// ===== rtl/wnav_pkg.sv =====
// ----------------------------------------------------------------------------
// wnav_pkg: shared types and constants of the NAV carrier-sense unit
// Command codes, state encodings, channel-width codes and the secondary
// channel availability rule.
// ----------------------------------------------------------------------------
package wnav_pkg;

   // Defaults for the top-level parameters
   localparam int AGE_WIDTH_DEFAULT      = 16;
   localparam int REVISION_WIDTH_DEFAULT = 16;

   // Configuration register addresses (byte addresses, 64-bit registers)
   localparam int         CSR_ADDR_WIDTH = 4;
   localparam logic [3:0] CSR_OWN_ADDRESS = 4'h0;

   // Event carried by one input beat
   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_RX_FRAME = 3'd1,
      CMD_TX_FRAME = 3'd2,
      CMD_RX_STATE = 3'd3,
      CMD_SIG_PART = 3'd4,
      CMD_TX_STATE = 3'd5,
      CMD_CCA      = 3'd6,
      CMD_QUERY    = 3'd7
   } cmd_type;

   // Receive state
   localparam logic [1:0] RX_UNDEF     = 2'd0;
   localparam logic [1:0] RX_IDLE      = 2'd1;
   localparam logic [1:0] RX_BUSY      = 2'd2;
   localparam logic [1:0] RX_RECEIVING = 2'd3;

   // Signal part
   localparam logic [2:0] SIG_NONE     = 3'd0;
   localparam logic [2:0] SIG_WHOLE    = 3'd1;
   localparam logic [2:0] SIG_PREAMBLE = 3'd2;
   localparam logic [2:0] SIG_HEADER   = 3'd3;
   localparam logic [2:0] SIG_DATA     = 3'd4;

   // Transmit state
   localparam logic [1:0] TX_UNDEF        = 2'd0;
   localparam logic [1:0] TX_IDLE         = 2'd1;
   localparam logic [1:0] TX_TRANSMITTING = 2'd2;

   // Channel width codes
   localparam logic [2:0] WIDTH_20   = 3'd0;
   localparam logic [2:0] WIDTH_40   = 3'd1;
   localparam logic [2:0] WIDTH_80   = 3'd2;
   localparam logic [2:0] WIDTH_160  = 3'd3;
   localparam logic [2:0] WIDTH_8080 = 3'd4;

   // Secondary channel index
   localparam logic [1:0] SEC_20 = 2'd0;
   localparam logic [1:0] SEC_40 = 2'd1;
   localparam logic [1:0] SEC_80 = 2'd2;

   // Secondary channel is usable under the held snapshot configuration
   function automatic logic sec_available(logic on, logic [2:0] w, logic [1:0] k);
      logic avail;
      avail = 1'b0;
      if (on) begin
         case (k)
            SEC_20: begin
               avail = (w != WIDTH_20);
            end
            SEC_40: begin
               avail = (w == WIDTH_80) || (w == WIDTH_160) || (w == WIDTH_8080);
            end
            SEC_80: begin
               avail = (w == WIDTH_160) || (w == WIDTH_8080);
            end
            default: begin
               avail = 1'b0;
            end
         endcase
      end
      return avail;
   endfunction

endpackage

// ===== rtl/wlan_nav_carrier_sense_unit.sv =====
// ----------------------------------------------------------------------------
// wlan_nav_carrier_sense_unit: 802.11 MAC carrier sense with NAV and CCA ages
// Virtual carrier countdown, primary medium state and secondary channel
// idle ages, updated by one event beat and reported on every beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event per beat (tick, rx/tx frame, rx state, signal
//   part, tx state, CCA snapshot or plain query). Every accepted beat yields
//   exactly one rsp_* beat with the medium, frame, NAV, reception and
//   channel-idle status as seen after that event.
//   A beat passes through an input register, then one pass of update logic
//   into the state and result registers.
//   Throughput is one beat per cycle while rsp_stall is low; the state update
//   of one beat is finished in the cycle before the next beat is evaluated.
//   When rsp_stall is high the result register holds its beat; one more
//   beat is taken into the input register, after which req_stall rises
//   until the result is taken.
//   csr_* is an APB-style port with one 64-bit register, own_address, at
//   byte address 0 (48 bits used). pready is tied high.
//   Reset (synchronous, active high) clears NAV, radio states, snapshot,
//   idle ages, the medium flag, own_address and both valid flags.
// ----------------------------------------------------------------------------
module wlan_nav_carrier_sense_unit #(
   parameter int AGE_WIDTH      = wnav_pkg::AGE_WIDTH_DEFAULT,
   parameter int REVISION_WIDTH = wnav_pkg::REVISION_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // event channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_command,
   input  logic [14:0]                         req_duration,
   input  logic [47:0]                         req_receiver_address,
   input  logic                                req_fcs_ok,
   input  logic [2:0]                          req_state_value,
   input  logic                                req_cca_enabled,
   input  logic [2:0]                          req_cca_width,
   input  logic [15:0]                         req_cca_revision,
   input  logic [3:0]                          req_busy_mask,
   input  logic [2:0]                          req_query_width,
   input  logic [15:0]                         req_query_interval,
   // status channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_medium_free,
   output logic                                rsp_medium_changed,
   output logic                                rsp_frame_ok,
   output logic                                rsp_corrupted_frame,
   output logic                                rsp_nav_active,
   output logic [14:0]                         rsp_nav_remaining,
   output logic                                rsp_reception_in_progress,
   output logic                                rsp_channel_idle,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wnav_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [63:0]                         csr_pwdata,
   output logic [63:0]                         csr_prdata,
   output logic                                csr_pready
);

   // Revision bits kept: the snapshot field is 16 bits, masked further
   // when REVISION_WIDTH is narrower.
   localparam int REV_W = (REVISION_WIDTH < 16) ? REVISION_WIDTH : 16;
   // Common width for comparing an idle age with the query interval
   localparam int CMP_W = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [47:0] own_address_ff;
   logic [47:0] own_address_in;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      own_address_in = own_address_ff;
      if (csr_write && (csr_paddr == wnav_pkg::CSR_OWN_ADDRESS)) begin
         own_address_in = csr_pwdata[47:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == wnav_pkg::CSR_OWN_ADDRESS) begin
         csr_prdata = {16'b0, own_address_ff};
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: input register in front, result register behind.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic advance;
   logic accept_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept_in = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept_in) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   // Input register payload
   wnav_pkg::cmd_type s1_command_ff;
   logic [14:0]       s1_duration_ff;
   logic [47:0]       s1_receiver_address_ff;
   logic              s1_fcs_ok_ff;
   logic [2:0]        s1_state_value_ff;
   logic              s1_cca_enabled_ff;
   logic [2:0]        s1_cca_width_ff;
   logic [15:0]       s1_cca_revision_ff;
   logic [3:0]        s1_busy_mask_ff;
   logic [2:0]        s1_query_width_ff;
   logic [15:0]       s1_query_interval_ff;

   always_ff @(posedge clock) begin
      if (accept_in) begin
         s1_command_ff          <= wnav_pkg::cmd_type'(req_command);
         s1_duration_ff         <= req_duration;
         s1_receiver_address_ff <= req_receiver_address;
         s1_fcs_ok_ff           <= req_fcs_ok;
         s1_state_value_ff      <= req_state_value;
         s1_cca_enabled_ff      <= req_cca_enabled;
         s1_cca_width_ff        <= req_cca_width;
         s1_cca_revision_ff     <= req_cca_revision;
         s1_busy_mask_ff        <= req_busy_mask;
         s1_query_width_ff      <= req_query_width;
         s1_query_interval_ff   <= req_query_interval;
      end
   end

   // ---------------------------------------------------------------------
   // Carrier-sense state
   // ---------------------------------------------------------------------
   logic [14:0]          nav_count_ff,      nav_count_in;
   logic [1:0]           rx_state_ff,       rx_state_in;
   logic [2:0]           signal_part_ff,    signal_part_in;
   logic [1:0]           tx_state_ff,       tx_state_in;
   logic                 cca_on_ff,         cca_on_in;
   logic [2:0]           cca_width_ff,      cca_width_in;
   logic [REV_W-1:0]     cca_revision_ff,   cca_revision_in;
   logic [3:0]           busy_ff,           busy_in;
   logic [AGE_WIDTH-1:0] age_ff [3];
   logic [AGE_WIDTH-1:0] age_in [3];
   logic [2:0]           age_valid_ff,      age_valid_in;
   logic                 medium_free_ff,    medium_free_in;

   // Result register payload
   logic        rsp_medium_changed_ff,        rsp_medium_changed_in;
   logic        rsp_frame_ok_ff,              rsp_frame_ok_in;
   logic        rsp_corrupted_frame_ff,       rsp_corrupted_frame_in;
   logic        rsp_reception_ff,             rsp_reception_in;
   logic        rsp_channel_idle_ff,          rsp_channel_idle_in;

   // Working signals of the update pass
   logic [REV_W-1:0] rev_masked;
   logic             reset_hist;
   logic [2:0]       old_avail;
   logic [2:0]       new_avail;
   logic [2:0]       sec_idle;
   logic             primary_idle;
   logic             nav_load;

   // NAV only ever lengthens: nonzero and at least the running count
   always_comb begin
      nav_load = (s1_duration_ff != 15'd0) && (s1_duration_ff >= nav_count_ff);
   end

   always_comb begin
      nav_count_in           = nav_count_ff;
      rx_state_in            = rx_state_ff;
      signal_part_in         = signal_part_ff;
      tx_state_in            = tx_state_ff;
      cca_on_in              = cca_on_ff;
      cca_width_in           = cca_width_ff;
      cca_revision_in        = cca_revision_ff;
      busy_in                = busy_ff;
      age_in                 = age_ff;
      age_valid_in           = age_valid_ff;
      rsp_frame_ok_in        = 1'b0;
      rsp_corrupted_frame_in = 1'b0;

      rev_masked = s1_cca_revision_ff[REV_W-1:0];
      reset_hist = (s1_cca_enabled_ff != cca_on_ff) ||
                   (s1_cca_width_ff != cca_width_ff) ||
                   (rev_masked != cca_revision_ff);
      for (int k = 0; k < 3; k++) begin
         old_avail[k] = wnav_pkg::sec_available(cca_on_ff, cca_width_ff, 2'(k));
         new_avail[k] = wnav_pkg::sec_available(s1_cca_enabled_ff, s1_cca_width_ff,
                                                2'(k));
      end

      case (s1_command_ff)
         wnav_pkg::CMD_TICK: begin
            if (nav_count_ff != 15'd0) begin
               nav_count_in = nav_count_ff - 15'd1;
            end
            for (int k = 0; k < 3; k++) begin
               if (age_valid_ff[k] && (age_ff[k] != {AGE_WIDTH{1'b1}})) begin
                  age_in[k] = age_ff[k] + AGE_WIDTH'(1);
               end
            end
         end
         wnav_pkg::CMD_RX_FRAME: begin
            if (s1_fcs_ok_ff) begin
               rsp_frame_ok_in = 1'b1;
               if ((s1_receiver_address_ff != own_address_ff) && nav_load) begin
                  nav_count_in = s1_duration_ff;
               end
            end else begin
               rsp_corrupted_frame_in = 1'b1;
            end
         end
         wnav_pkg::CMD_TX_FRAME: begin
            if (nav_load) begin
               nav_count_in = s1_duration_ff;
            end
         end
         wnav_pkg::CMD_RX_STATE: begin
            if (s1_state_value_ff inside {[3'd0:3'd3]}) begin
               rx_state_in = s1_state_value_ff[1:0];
            end
         end
         wnav_pkg::CMD_SIG_PART: begin
            if (s1_state_value_ff inside {[3'd0:3'd4]}) begin
               signal_part_in = s1_state_value_ff;
            end
         end
         wnav_pkg::CMD_TX_STATE: begin
            if (s1_state_value_ff inside {[3'd0:3'd2]}) begin
               tx_state_in = s1_state_value_ff[1:0];
            end
         end
         wnav_pkg::CMD_CCA: begin
            cca_on_in       = s1_cca_enabled_ff;
            cca_width_in    = s1_cca_width_ff;
            cca_revision_in = rev_masked;
            busy_in         = s1_busy_mask_ff;
            for (int k = 0; k < 3; k++) begin
               if (!new_avail[k] || s1_busy_mask_ff[k+1]) begin
                  age_valid_in[k] = 1'b0;
                  age_in[k]       = '0;
               end else if (reset_hist || !old_avail[k] || !age_valid_ff[k]) begin
                  age_valid_in[k] = 1'b1;
                  age_in[k]       = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Status after the update
   always_comb begin
      primary_idle = (rx_state_in != wnav_pkg::RX_RECEIVING) &&
                     (cca_on_in ? !busy_in[0] : (rx_state_in == wnav_pkg::RX_IDLE));
      medium_free_in = primary_idle && (tx_state_in == wnav_pkg::TX_UNDEF) &&
                       (nav_count_in == 15'd0);
      rsp_medium_changed_in = (medium_free_in != medium_free_ff);
      rsp_reception_in = (rx_state_in == wnav_pkg::RX_RECEIVING) &&
                         ((signal_part_in == wnav_pkg::SIG_WHOLE) ||
                          (signal_part_in == wnav_pkg::SIG_DATA));

      for (int k = 0; k < 3; k++) begin
         sec_idle[k] = wnav_pkg::sec_available(cca_on_in, cca_width_in, 2'(k)) &&
                       !busy_in[k+1] && age_valid_in[k] &&
                       (CMP_W'(age_in[k]) >= CMP_W'(s1_query_interval_ff));
      end

      rsp_channel_idle_in = 1'b1;
      if (cca_on_in) begin
         case (s1_query_width_ff)
            wnav_pkg::WIDTH_20: begin
               rsp_channel_idle_in = 1'b1;
            end
            wnav_pkg::WIDTH_40: begin
               rsp_channel_idle_in = sec_idle[0];
            end
            wnav_pkg::WIDTH_80: begin
               rsp_channel_idle_in = sec_idle[0] && sec_idle[1];
            end
            wnav_pkg::WIDTH_160: begin
               rsp_channel_idle_in = &sec_idle;
            end
            default: begin
               rsp_channel_idle_in = 1'b0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff  <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         nav_count_ff    <= '0;
         rx_state_ff     <= wnav_pkg::RX_UNDEF;
         signal_part_ff  <= wnav_pkg::SIG_NONE;
         tx_state_ff     <= wnav_pkg::TX_UNDEF;
         cca_on_ff       <= 1'b0;
         cca_width_ff    <= wnav_pkg::WIDTH_20;
         cca_revision_ff <= '0;
         busy_ff         <= '0;
         age_ff          <= '{default: '0};
         age_valid_ff    <= '0;
         medium_free_ff  <= 1'b0;
      end else begin
         own_address_ff <= own_address_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         // commit the state of one beat as it moves into the result register
         if (advance) begin
            nav_count_ff    <= nav_count_in;
            rx_state_ff     <= rx_state_in;
            signal_part_ff  <= signal_part_in;
            tx_state_ff     <= tx_state_in;
            cca_on_ff       <= cca_on_in;
            cca_width_ff    <= cca_width_in;
            cca_revision_ff <= cca_revision_in;
            busy_ff         <= busy_in;
            age_ff          <= age_in;
            age_valid_ff    <= age_valid_in;
            medium_free_ff  <= medium_free_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_medium_changed_ff  <= rsp_medium_changed_in;
         rsp_frame_ok_ff        <= rsp_frame_ok_in;
         rsp_corrupted_frame_ff <= rsp_corrupted_frame_in;
         rsp_reception_ff       <= rsp_reception_in;
         rsp_channel_idle_ff    <= rsp_channel_idle_in;
      end
   end

   // Medium flag and NAV count are state; the result reads them directly.
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_medium_free           = medium_free_ff;
   assign rsp_medium_changed        = rsp_medium_changed_ff;
   assign rsp_frame_ok              = rsp_frame_ok_ff;
   assign rsp_corrupted_frame       = rsp_corrupted_frame_ff;
   assign rsp_nav_active            = (nav_count_ff != 15'd0);
   assign rsp_nav_remaining         = nav_count_ff;
   assign rsp_reception_in_progress = rsp_reception_ff;
   assign rsp_channel_idle          = rsp_channel_idle_ff;

endmodule

// ===== test/wlan_nav_carrier_sense_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wlan_nav_carrier_sense_unit_tb: self-checking bench for the carrier-sense unit
// Drives event beats through the valid/stall channel and programs own_address
// over the APB-style port while the unit is idle. A beat-level model of the
// NAV countdown, radio states, CCA snapshot and secondary idle ages predicts
// every status beat, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module wlan_nav_carrier_sense_unit_tb;

   localparam int          AGE_BITS    = wnav_pkg::AGE_WIDTH_DEFAULT;
   localparam int          REV_BITS    = wnav_pkg::REVISION_WIDTH_DEFAULT;
   localparam logic [15:0] REV_MASK    = 16'((64'd1 << REV_BITS) - 1);
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          MAX_REPORTS = 40;
   localparam int          PHASE_BEATS = 290;
   localparam int          AGE_TICKS   = 64;

   // one event beat as the sender sees it
   typedef struct {
      wnav_pkg::cmd_type command;
      logic [14:0]       duration;
      logic [47:0]       receiver_address;
      logic              fcs_ok;
      logic [2:0]        state_value;
      logic              cca_enabled;
      logic [2:0]        cca_width;
      logic [15:0]       cca_revision;
      logic [3:0]        busy_mask;
      logic [2:0]        query_width;
      logic [15:0]       query_interval;
   } nav_event_type;

   // one status beat
   typedef struct packed {
      logic        medium_free;
      logic        medium_changed;
      logic        frame_ok;
      logic        corrupted_frame;
      logic        nav_active;
      logic [14:0] nav_remaining;
      logic        reception_in_progress;
      logic        channel_idle;
   } sense_status_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   // event channel
   logic        req_valid            = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command          = '0;
   logic [14:0] req_duration         = '0;
   logic [47:0] req_receiver_address = '0;
   logic        req_fcs_ok           = 1'b0;
   logic [2:0]  req_state_value      = '0;
   logic        req_cca_enabled      = 1'b0;
   logic [2:0]  req_cca_width        = '0;
   logic [15:0] req_cca_revision     = '0;
   logic [3:0]  req_busy_mask        = '0;
   logic [2:0]  req_query_width      = '0;
   logic [15:0] req_query_interval   = '0;

   // status channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_medium_free;
   logic        rsp_medium_changed;
   logic        rsp_frame_ok;
   logic        rsp_corrupted_frame;
   logic        rsp_nav_active;
   logic [14:0] rsp_nav_remaining;
   logic        rsp_reception_in_progress;
   logic        rsp_channel_idle;

   // configuration port
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [wnav_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [63:0]                         csr_pwdata  = '0;
   logic [63:0]                         csr_prdata;
   logic                                csr_pready;

   // bench bookkeeping
   int               error_count     = 0;
   int unsigned      cycle_count     = 0;
   int               beats_sent      = 0;
   int               sender_idle_pct = 0;
   int               stall_pct       = 0;
   sense_status_type pending_status[$];

   // predicted unit state
   logic [47:0]         m_own_address;
   logic [14:0]         m_nav;
   logic [1:0]          m_rx_state;
   logic [2:0]          m_signal_part;
   logic [1:0]          m_tx_state;
   logic                m_cca_on;
   logic [2:0]          m_cca_width;
   logic [15:0]         m_cca_rev;
   logic [3:0]          m_busy;
   logic [AGE_BITS-1:0] m_age[0:2];
   logic                m_age_ok[0:2];
   logic                m_medium_free;

   wlan_nav_carrier_sense_unit DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_command              (req_command),
      .req_duration             (req_duration),
      .req_receiver_address     (req_receiver_address),
      .req_fcs_ok               (req_fcs_ok),
      .req_state_value          (req_state_value),
      .req_cca_enabled          (req_cca_enabled),
      .req_cca_width            (req_cca_width),
      .req_cca_revision         (req_cca_revision),
      .req_busy_mask            (req_busy_mask),
      .req_query_width          (req_query_width),
      .req_query_interval       (req_query_interval),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_medium_free          (rsp_medium_free),
      .rsp_medium_changed       (rsp_medium_changed),
      .rsp_frame_ok             (rsp_frame_ok),
      .rsp_corrupted_frame      (rsp_corrupted_frame),
      .rsp_nav_active           (rsp_nav_active),
      .rsp_nav_remaining        (rsp_nav_remaining),
      .rsp_reception_in_progress(rsp_reception_in_progress),
      .rsp_channel_idle         (rsp_channel_idle),
      .csr_psel                 (csr_psel),
      .csr_penable              (csr_penable),
      .csr_pwrite               (csr_pwrite),
      .csr_paddr                (csr_paddr),
      .csr_pwdata               (csr_pwdata),
      .csr_prdata               (csr_prdata),
      .csr_pready               (csr_pready)
   );

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Secondary channel k exists under a snapshot of this enable and width.
   // Odd widths (5..7) still count as wider than 20, so only the secondary
   // 20 channel survives for them.
   function automatic logic sec_usable(input logic on, input logic [2:0] w,
                                       input logic [1:0] k);
      if (!on) begin
         return 1'b0;
      end
      case (k)
         wnav_pkg::SEC_20: begin
            return w != wnav_pkg::WIDTH_20;
         end
         wnav_pkg::SEC_40: begin
            return w inside {wnav_pkg::WIDTH_80, wnav_pkg::WIDTH_160, wnav_pkg::WIDTH_8080};
         end
         wnav_pkg::SEC_80: begin
            return w inside {wnav_pkg::WIDTH_160, wnav_pkg::WIDTH_8080};
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic logic sec_idle(input logic [1:0] k, input logic [15:0] interval);
      return sec_usable(m_cca_on, m_cca_width, k) && !m_busy[k + 1] && m_age_ok[k] &&
             m_age[k] >= interval;
   endfunction

   // Without CCA every width reads as idle; 20 MHz always does, and with CCA on
   // 80+80 plus the odd codes never do.
   function automatic logic channel_idle_for(input logic [2:0] w,
                                             input logic [15:0] interval);
      if (!m_cca_on) begin
         return 1'b1;
      end
      case (w)
         wnav_pkg::WIDTH_20: begin
            return 1'b1;
         end
         wnav_pkg::WIDTH_40: begin
            return sec_idle(wnav_pkg::SEC_20, interval);
         end
         wnav_pkg::WIDTH_80: begin
            return sec_idle(wnav_pkg::SEC_20, interval) &&
                   sec_idle(wnav_pkg::SEC_40, interval);
         end
         wnav_pkg::WIDTH_160: begin
            return sec_idle(wnav_pkg::SEC_20, interval) &&
                   sec_idle(wnav_pkg::SEC_40, interval) &&
                   sec_idle(wnav_pkg::SEC_80, interval);
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   // NAV only grows: zero and shorter durations leave it alone
   function automatic void nav_extend(input logic [14:0] dur);
      if (dur != 0 && dur >= m_nav) begin
         m_nav = dur;
      end
   endfunction

   function automatic sense_status_type carrier_sense_update(input nav_event_type ev);
      sense_status_type st;
      logic             was_free;
      logic             hist_reset;
      logic             usable_before[0:2];
      logic [15:0]      rev;
      logic             primary_idle;
      int               k;
      st       = '0;
      was_free = m_medium_free;
      case (ev.command)
         wnav_pkg::CMD_TICK: begin
            if (m_nav != 0) begin
               m_nav = m_nav - 1'b1;
            end
            for (k = 0; k < 3; k++) begin
               if (m_age_ok[k] && m_age[k] != '1) begin
                  m_age[k] = m_age[k] + 1'b1;
               end
            end
         end
         wnav_pkg::CMD_RX_FRAME: begin
            if (ev.fcs_ok) begin
               st.frame_ok = 1'b1;
               if (ev.receiver_address != m_own_address) begin
                  nav_extend(ev.duration);
               end
            end else begin
               st.corrupted_frame = 1'b1;
            end
         end
         wnav_pkg::CMD_TX_FRAME: begin
            nav_extend(ev.duration);
         end
         wnav_pkg::CMD_RX_STATE: begin
            if (ev.state_value <= 3'(wnav_pkg::RX_RECEIVING)) begin
               m_rx_state = ev.state_value[1:0];
            end
         end
         wnav_pkg::CMD_SIG_PART: begin
            if (ev.state_value <= wnav_pkg::SIG_DATA) begin
               m_signal_part = ev.state_value;
            end
         end
         wnav_pkg::CMD_TX_STATE: begin
            if (ev.state_value <= 3'(wnav_pkg::TX_TRANSMITTING)) begin
               m_tx_state = ev.state_value[1:0];
            end
         end
         wnav_pkg::CMD_CCA: begin
            rev = ev.cca_revision & REV_MASK;
            for (k = 0; k < 3; k++) begin
               usable_before[k] = sec_usable(m_cca_on, m_cca_width, 2'(k));
            end
            hist_reset = (ev.cca_enabled != m_cca_on) || (ev.cca_width != m_cca_width) ||
                         (rev != m_cca_rev);
            m_cca_on    = ev.cca_enabled;
            m_cca_width = ev.cca_width;
            m_cca_rev   = rev;
            m_busy      = ev.busy_mask;
            for (k = 0; k < 3; k++) begin
               if (!sec_usable(m_cca_on, m_cca_width, 2'(k)) || ev.busy_mask[k + 1]) begin
                  m_age_ok[k] = 1'b0;
                  m_age[k]    = '0;
               end else if (hist_reset || !usable_before[k] || !m_age_ok[k]) begin
                  m_age_ok[k] = 1'b1;
                  m_age[k]    = '0;
               end
            end
         end
         default: begin
         end
      endcase

      primary_idle  = (m_rx_state != wnav_pkg::RX_RECEIVING) &&
                      (m_cca_on ? !m_busy[0] : (m_rx_state == wnav_pkg::RX_IDLE));
      m_medium_free = primary_idle && (m_tx_state == wnav_pkg::TX_UNDEF) && (m_nav == 0);

      st.medium_free           = m_medium_free;
      st.medium_changed        = m_medium_free != was_free;
      st.nav_active            = m_nav != 0;
      st.nav_remaining         = m_nav;
      st.reception_in_progress = (m_rx_state == wnav_pkg::RX_RECEIVING) &&
                                 (m_signal_part == wnav_pkg::SIG_WHOLE ||
                                  m_signal_part == wnav_pkg::SIG_DATA);
      st.channel_idle          = channel_idle_for(ev.query_width, ev.query_interval);
      return st;
   endfunction

   // ------------------------------------------------------------------------
   // Status checking: compare every accepted status beat against the oldest
   // prediction; report only the first few failures to keep the log short.
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [14:0] want,
                              input logic [14:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      end
   endtask

   sense_status_type want_status;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: status beat with none expected, expected none, actual %0d",
                        $time, rsp_nav_remaining);
            end
         end else begin
            want_status = pending_status.pop_front();
            check_field("medium_free", 15'(want_status.medium_free), 15'(rsp_medium_free));
            check_field("medium_changed", 15'(want_status.medium_changed),
                        15'(rsp_medium_changed));
            check_field("frame_ok", 15'(want_status.frame_ok), 15'(rsp_frame_ok));
            check_field("corrupted_frame", 15'(want_status.corrupted_frame),
                        15'(rsp_corrupted_frame));
            check_field("nav_active", 15'(want_status.nav_active), 15'(rsp_nav_active));
            check_field("nav_remaining", want_status.nav_remaining, rsp_nav_remaining);
            check_field("reception_in_progress", 15'(want_status.reception_in_progress),
                        15'(rsp_reception_in_progress));
            check_field("channel_idle", 15'(want_status.channel_idle),
                        15'(rsp_channel_idle));
         end
      end
   end

   // Receiver back-pressure: stall at the rate the current phase asks for
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Present one beat and hold it until accepted. Valid stays high after the
   // accepting edge so back-to-back beats never toggle it within one step;
   // drop it only when an idle gap is drawn or the bench goes quiet.
   task automatic send_beat(input nav_event_type ev);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_command          <= ev.command;
      req_duration         <= ev.duration;
      req_receiver_address <= ev.receiver_address;
      req_fcs_ok           <= ev.fcs_ok;
      req_state_value      <= ev.state_value;
      req_cca_enabled      <= ev.cca_enabled;
      req_cca_width        <= ev.cca_width;
      req_cca_revision     <= ev.cca_revision;
      req_busy_mask        <= ev.busy_mask;
      req_query_width      <= ev.query_width;
      req_query_interval   <= ev.query_interval;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_status.insert(pending_status.size(), carrier_sense_update(ev));
      beats_sent++;
   endtask

   // Drop valid and hold off until every predicted status has arrived, then
   // wait on to cover the two-stage pipeline.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   // APB write of own_address: setup cycle, access cycle, done at the edge
   // where psel, penable and pwrite are all high (pready is tied high).
   task automatic write_own_address(input logic [63:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= wnav_pkg::CSR_OWN_ADDRESS;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      m_own_address = value[47:0];
   endtask

   function automatic nav_event_type blank_event(input wnav_pkg::cmd_type cmd);
      nav_event_type ev;
      ev.command          = cmd;
      ev.duration         = '0;
      ev.receiver_address = '0;
      ev.fcs_ok           = 1'b0;
      ev.state_value      = '0;
      ev.cca_enabled      = 1'b0;
      ev.cca_width        = wnav_pkg::WIDTH_20;
      ev.cca_revision     = '0;
      ev.busy_mask        = '0;
      ev.query_width      = wnav_pkg::WIDTH_20;
      ev.query_interval   = '0;
      return ev;
   endfunction

   task automatic send_state(input wnav_pkg::cmd_type cmd, input logic [2:0] value);
      nav_event_type ev;
      ev             = blank_event(cmd);
      ev.state_value = value;
      send_beat(ev);
   endtask

   // Random beat biased toward ticks, short NAVs, mostly stable CCA setups and
   // small query intervals, so the idle ages actually answer queries.
   function automatic nav_event_type random_event();
      nav_event_type ev;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         ev.command = wnav_pkg::CMD_TICK;
      end else if (pick < 52) begin
         ev.command = wnav_pkg::CMD_RX_FRAME;
      end else if (pick < 60) begin
         ev.command = wnav_pkg::CMD_TX_FRAME;
      end else if (pick < 69) begin
         ev.command = wnav_pkg::CMD_RX_STATE;
      end else if (pick < 77) begin
         ev.command = wnav_pkg::CMD_SIG_PART;
      end else if (pick < 84) begin
         ev.command = wnav_pkg::CMD_TX_STATE;
      end else if (pick < 95) begin
         ev.command = wnav_pkg::CMD_CCA;
      end else begin
         ev.command = wnav_pkg::CMD_QUERY;
      end
      ev.duration = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 60));
      ev.receiver_address = ($urandom_range(0, 9) < 3) ? m_own_address :
                            {16'($urandom), $urandom};
      ev.fcs_ok      = ($urandom_range(0, 99) < 85);
      ev.state_value = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
                                                     3'($urandom_range(0, 4));
      if ($urandom_range(0, 3) != 0) begin
         // keep the held setup (once CCA is on) so histories survive, only busy bits move
         ev.cca_enabled  = 1'b1;
         ev.cca_width    = m_cca_on ? m_cca_width : 3'($urandom_range(1, 4));
         ev.cca_revision = m_cca_rev;
      end else begin
         ev.cca_enabled  = ($urandom_range(0, 99) < 85);
         ev.cca_width    = 3'($urandom_range(0, 7));
         ev.cca_revision = $urandom_range(0, 1) ? m_cca_rev : 16'($urandom);
      end
      ev.busy_mask = {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0};
      ev.query_width    = 3'($urandom_range(0, 7));
      ev.query_interval = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 40)) :
                                                       16'($urandom);
      return ev;
   endfunction

   // Well-formed radio activity with random contents and a few ticks between
   // the steps: a reception (rx receiving, preamble, header, payload part,
   // frame, back to idle or busy, no signal part) or an own transmission.
   task automatic send_radio_sequence(input logic transmit);
      wnav_pkg::cmd_type step_cmd[$];
      logic [2:0]        step_val[$];
      nav_event_type     ev;
      int                i;
      if (transmit) begin
         step_cmd = '{wnav_pkg::CMD_TX_STATE, wnav_pkg::CMD_TX_FRAME,
                      wnav_pkg::CMD_TX_STATE};
         step_val = '{3'(wnav_pkg::TX_TRANSMITTING), 3'd0,
                      ($urandom_range(0, 9) == 0) ? 3'(wnav_pkg::TX_IDLE) :
                                                    3'(wnav_pkg::TX_UNDEF)};
      end else begin
         step_cmd = '{wnav_pkg::CMD_RX_STATE, wnav_pkg::CMD_SIG_PART,
                      wnav_pkg::CMD_SIG_PART, wnav_pkg::CMD_SIG_PART,
                      wnav_pkg::CMD_RX_FRAME, wnav_pkg::CMD_RX_STATE,
                      wnav_pkg::CMD_SIG_PART};
         step_val = '{3'(wnav_pkg::RX_RECEIVING), wnav_pkg::SIG_PREAMBLE,
                      wnav_pkg::SIG_HEADER,
                      $urandom_range(0, 1) ? wnav_pkg::SIG_DATA : wnav_pkg::SIG_WHOLE,
                      3'd0,
                      ($urandom_range(0, 4) == 0) ? 3'(wnav_pkg::RX_BUSY) :
                                                    3'(wnav_pkg::RX_IDLE),
                      wnav_pkg::SIG_NONE};
      end
      for (i = 0; i < step_cmd.size(); i++) begin
         ev             = random_event();
         ev.command     = step_cmd[i];
         ev.state_value = step_val[i];
         send_beat(ev);
         repeat ($urandom_range(0, 3)) begin
            ev         = random_event();
            ev.command = wnav_pkg::CMD_TICK;
            send_beat(ev);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Frame status and NAV rules: corrupted frame, own-address frame, zero and
   // shorter durations, then an equal NAV from both frame sources.
   task automatic test_frame_nav();
      nav_event_type ev;
      write_own_address(64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(blank_event(wnav_pkg::CMD_QUERY));
      ev = blank_event(wnav_pkg::CMD_RX_FRAME);
      ev.duration = 15'd100;
      ev.receiver_address = 48'h0123_4567_89AB;
      send_beat(ev);
      ev.fcs_ok = 1'b1;
      ev.duration = 15'd500;
      ev.receiver_address = 48'hFFFF_FFFF_FFFF;
      send_beat(ev);
      ev.receiver_address = '0;
      ev.duration = 15'd0;
      send_beat(ev);
      ev.duration = 15'd40;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_TX_FRAME);
      ev.duration = 15'd10;
      send_beat(ev);
      send_beat(blank_event(wnav_pkg::CMD_TICK));
      ev.duration = 15'd300;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_RX_FRAME);
      ev.fcs_ok = 1'b1;
      ev.duration = 15'd300;
      ev.receiver_address = 48'h0000_0000_0123;
      send_beat(ev);
   endtask

   // Radio states, reception-in-progress combinations and ignored codes
   task automatic test_radio_states();
      send_state(wnav_pkg::CMD_RX_STATE, 3'(wnav_pkg::RX_RECEIVING));
      send_state(wnav_pkg::CMD_SIG_PART, wnav_pkg::SIG_WHOLE);
      send_state(wnav_pkg::CMD_SIG_PART, 3'd5);
      send_state(wnav_pkg::CMD_SIG_PART, wnav_pkg::SIG_DATA);
      send_state(wnav_pkg::CMD_SIG_PART, wnav_pkg::SIG_PREAMBLE);
      send_state(wnav_pkg::CMD_RX_STATE, 3'd7);
      send_state(wnav_pkg::CMD_RX_STATE, 3'(wnav_pkg::RX_IDLE));
      send_state(wnav_pkg::CMD_TX_STATE, 3'(wnav_pkg::TX_TRANSMITTING));
      send_state(wnav_pkg::CMD_TX_STATE, 3'd3);
      send_state(wnav_pkg::CMD_TX_STATE, 3'(wnav_pkg::TX_UNDEF));
   endtask

   // Snapshot handling: widest setup with full revision, all-busy, an odd
   // width, primary busy and CCA switched off again
   task automatic test_cca_snapshot();
      nav_event_type ev;
      ev = blank_event(wnav_pkg::CMD_CCA);
      ev.cca_enabled  = 1'b1;
      ev.cca_width    = wnav_pkg::WIDTH_8080;
      ev.cca_revision = 16'hFFFF;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_TICK);
      ev.query_width    = wnav_pkg::WIDTH_40;
      ev.query_interval = 16'd1;
      send_beat(ev);
      ev.command = wnav_pkg::CMD_QUERY;
      ev.query_width = wnav_pkg::WIDTH_160;
      send_beat(ev);
      ev.query_width = wnav_pkg::WIDTH_8080;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_CCA);
      ev.cca_enabled  = 1'b1;
      ev.cca_width    = wnav_pkg::WIDTH_8080;
      ev.cca_revision = 16'hFFFF;
      ev.busy_mask    = 4'hF;
      ev.query_width  = wnav_pkg::WIDTH_40;
      send_beat(ev);
      ev.cca_width = 3'd7;
      ev.busy_mask = '0;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_TICK);
      ev.query_width    = wnav_pkg::WIDTH_40;
      ev.query_interval = 16'd1;
      send_beat(ev);
      ev.command     = wnav_pkg::CMD_QUERY;
      ev.query_width = 3'd7;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_CCA);
      ev.cca_enabled = 1'b1;
      ev.busy_mask   = 4'h1;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_CCA);
      ev.query_width    = wnav_pkg::WIDTH_8080;
      ev.query_interval = 16'hFFFF;
      send_beat(ev);
   endtask

   // Grow the secondary ages past a query interval so the 160 MHz answer flips
   task automatic test_age_growth();
      nav_event_type ev;
      ev = blank_event(wnav_pkg::CMD_CCA);
      ev.cca_enabled  = 1'b1;
      ev.cca_width    = wnav_pkg::WIDTH_160;
      ev.cca_revision = 16'd1;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_TICK);
      ev.query_width    = wnav_pkg::WIDTH_160;
      ev.query_interval = 16'd50;
      repeat (AGE_TICKS) send_beat(ev);
   endtask

   // Longest NAV from both frame sources
   task automatic test_longest_nav();
      nav_event_type ev;
      ev = blank_event(wnav_pkg::CMD_TX_FRAME);
      ev.duration = 15'h7FFF;
      send_beat(ev);
      ev = blank_event(wnav_pkg::CMD_RX_FRAME);
      ev.fcs_ok = 1'b1;
      ev.duration = 15'h7FFF;
      ev.receiver_address = 48'h0000_0000_0123;
      send_beat(ev);
      send_beat(blank_event(wnav_pkg::CMD_TICK));
   endtask

   task automatic test_random_traffic(input int beats, input int idle_pct,
                                      input int stall_rate);
      int first;
      int pick;
      sender_idle_pct = idle_pct;
      stall_pct       = stall_rate;
      first           = beats_sent;
      while (beats_sent - first < beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_radio_sequence(1'b0);
         end else if (pick < 18) begin
            send_radio_sequence(1'b1);
         end else begin
            send_beat(random_event());
         end
      end
      sender_idle_pct = 0;
      stall_pct       = 0;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // model mirrors the unit's reset state
      m_own_address = '0;
      m_nav         = '0;
      m_rx_state    = wnav_pkg::RX_UNDEF;
      m_signal_part = wnav_pkg::SIG_NONE;
      m_tx_state    = wnav_pkg::TX_UNDEF;
      m_cca_on      = 1'b0;
      m_cca_width   = wnav_pkg::WIDTH_20;
      m_cca_rev     = '0;
      m_busy        = '0;
      m_medium_free = 1'b0;
      for (int k = 0; k < 3; k++) begin
         m_age[k]    = '0;
         m_age_ok[k] = 1'b0;
      end

      // hold reset from the start, then release it once for good
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_frame_nav();
      test_radio_states();
      test_cca_snapshot();
      test_age_growth();

      // random phases; own_address changes only once the pipe is empty,
      // which also makes the sender pause until every status is back
      write_own_address(64'h0);
      test_random_traffic(PHASE_BEATS, 0, 0);
      write_own_address({$urandom, $urandom});
      test_random_traffic(PHASE_BEATS, 52, 0);
      write_own_address({32'h0, $urandom} | 64'hFFFF_0000_0000_0000);
      test_random_traffic(PHASE_BEATS, 0, 52);
      write_own_address({16'($urandom), 16'hFFFF, $urandom});
      test_random_traffic(PHASE_BEATS, 10, 10);

      test_longest_nav();

      // let the last status beats arrive and watch for strays
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_status.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wnav_pkg.sv
rtl/wlan_nav_carrier_sense_unit.sv
test/wlan_nav_carrier_sense_unit_tb.sv
